// ===== hdl/spb_pkg.sv =====
// Package for the skeletal pose blend block: shared types, widths, register indexes,
// controller states and the saturation helper. No dependencies.
`timescale 1ns / 1ps

package spb_pkg;

	localparam int MAX_BONES_DEF = 64;
	localparam int NUM_ROWS = 4;
	localparam int WORD_W = 32;
	localparam int WEIGHT_W = 16;
	localparam int IN_DATA_W = 272;
	localparam int OUT_DATA_W = 136;
	localparam int A_OFFSET = 14;
	localparam int B_OFFSET = 142;
	localparam int BLEND_W = 49;
	localparam int ACC_W = 66;

	localparam logic [WEIGHT_W-1:0] ONE_Q15 = 16'd32768;

	localparam logic REG_BLEND_WEIGHT = 1'b0;
	localparam logic REG_WEIGHT_ON_FIRST = 1'b1;

	typedef logic signed [WORD_W-1:0] word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BLEND,
		ST_NORM,
		ST_MAC,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic       blend_en;
		logic       norm_en;
		logic       rd_en;
		logic [1:0] rd_k;
		logic       mul_en;
		logic [1:0] mul_k;
		logic       acc_init;
		logic       acc_en;
		logic       par_zero;
		logic       root;
		logic       wr_en;
		logic [5:0] parent;
		logic [5:0] bone;
		logic [1:0] column;
	} lane_ctrl_t;

	function automatic word_t sat_word(input logic signed [63:0] v);
		word_t res;
		if (v > 64'sh0000_0000_7FFF_FFFF) begin
			res = 32'sh7FFF_FFFF;
		end else if (v < -64'sh0000_0000_8000_0000) begin
			res = -32'sh8000_0000;
		end else begin
			res = v[WORD_W-1:0];
		end
		return res;
	endfunction

endpackage

// ===== hdl/spb_lane.sv =====
// One row lane: blends its row of the two columns, keeps its row of the world store
// and multiplies the parent row by the blended column. Depends on spb_pkg.
`timescale 1ns / 1ps

module spb_lane #(
	parameter int MAX_BONES = spb_pkg::MAX_BONES_DEF
) (
	input  logic                  clk,
	input  spb_pkg::lane_ctrl_t   ctrl,
	input  spb_pkg::word_t        a_val,
	input  spb_pkg::word_t        b_val,
	input  logic [15:0]           wa,
	input  logic [15:0]           wb,
	input  spb_pkg::word_t        blend_col [spb_pkg::NUM_ROWS],
	output spb_pkg::word_t        blended,
	output spb_pkg::word_t        result
);
	import spb_pkg::*;

	localparam int Depth = MAX_BONES * 4;
	localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

	logic [WORD_W-1:0] bank_mem [Depth];
	logic [WORD_W-1:0] rdata_q;
	logic [AddrW-1:0] rd_addr;
	logic [AddrW-1:0] wr_addr;

	logic signed [BLEND_W-1:0] blend_sum;
	logic signed [BLEND_W-1:0] blend_s1;
	word_t blended_q;
	word_t pdata;
	logic signed [63:0] mul_res;
	logic signed [63:0] mprod_s2;
	logic signed [ACC_W-1:0] acc_q;

	assign rd_addr = AddrW'({ctrl.parent, ctrl.rd_k});
	assign wr_addr = AddrW'({ctrl.bone, ctrl.column});

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			bank_mem[wr_addr] <= result;
		end
		if (ctrl.rd_en) begin
			rdata_q <= bank_mem[rd_addr];
		end
	end

	assign blend_sum = a_val * $signed({1'b0, wa}) + b_val * $signed({1'b0, wb})
		+ 49'sd16384;
	assign pdata = ctrl.par_zero ? '0 : $signed(rdata_q);
	assign mul_res = pdata * blend_col[ctrl.mul_k];

	always_ff @(posedge clk) begin
		if (ctrl.blend_en) begin
			blend_s1 <= blend_sum;
		end
		if (ctrl.norm_en) begin
			blended_q <= sat_word(64'(blend_s1 >>> 15));
		end
		if (ctrl.mul_en) begin
			mprod_s2 <= mul_res;
		end
		if (ctrl.acc_init) begin
			acc_q <= 66'sd32768;
		end else if (ctrl.acc_en) begin
			acc_q <= acc_q + 66'(mprod_s2);
		end
	end

	assign blended = blended_q;
	assign result = ctrl.root ? blended_q : sat_word(64'(acc_q >>> 16));

endmodule

// ===== hdl/spb_merge.sv =====
// Output stage: gathers the four lane results with the bone and column tags into
// one registered result request. Depends on spb_pkg.
`timescale 1ns / 1ps

module spb_merge (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              load,
	input  logic [5:0]                        bone,
	input  logic [1:0]                        column,
	input  spb_pkg::word_t                    results [spb_pkg::NUM_ROWS],
	output logic                              free,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// out_bone, out_column, world_row0, world_row1, world_row2, world_row3
	output logic [spb_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
	import spb_pkg::*;

	logic valid_q;
	logic [OUT_DATA_W-1:0] tdata_q;

	assign free = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tdata_q <= {results[3], results[2], results[1], results[0], column, bone};
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata = tdata_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!valid_q || m_axis_tready))
		else $error("A result was loaded over one that was not yet taken.");

endmodule

// ===== hdl/skeletal_pose_blend.sv =====
// Skeletal pose blend top level: controller, four row lanes and the output stage.
// A root bone goes from blend and normalise straight to finish; any other bone first runs
// the four-step parent multiply-accumulate in each lane before its result is loaded.
// One item is in work at a time; the next may enter while a result waits on the output.
// arst_n clears control state and sets blend_weight to one and weight_on_first to 1.
`timescale 1ns / 1ps

module skeletal_pose_blend #(
	parameter int MAX_BONES = spb_pkg::MAX_BONES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// bone_index, parent_index, column_index, a_row0..a_row3, b_row0..b_row3, zero fill
	input  logic [spb_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// is_root
	input  logic                              s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// out_bone, out_column, world_row0, world_row1, world_row2, world_row3
	output logic [spb_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [15:0]                       cfg_data
);
	import spb_pkg::*;

	state_t state_q, state_d;
	logic [2:0] step_q, step_d;

	logic [15:0] blend_weight_q;
	logic weight_on_first_q;

	logic [5:0] bone_q;
	logic [5:0] parent_q;
	logic [1:0] column_q;
	logic root_q;
	logic bone_ok_q;
	logic par_ok_q;
	word_t a_q [NUM_ROWS];
	word_t b_q [NUM_ROWS];
	logic [15:0] wa_q;
	logic [15:0] wb_q;

	logic [15:0] w_clamped;
	logic [15:0] wa_next;
	logic accept;
	logic out_free;
	logic load;
	lane_ctrl_t ctrl;
	word_t blend_col [NUM_ROWS];
	word_t results [NUM_ROWS];

	assign accept = s_axis_tvalid && s_axis_tready;
	assign w_clamped = (blend_weight_q > ONE_Q15) ? ONE_Q15 : blend_weight_q;
	assign wa_next = weight_on_first_q ? w_clamped : ONE_Q15 - w_clamped;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_weight_q <= ONE_Q15;
			weight_on_first_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BLEND_WEIGHT: blend_weight_q <= cfg_data;
				REG_WEIGHT_ON_FIRST: weight_on_first_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bone_q <= s_axis_tdata[5:0];
			parent_q <= s_axis_tdata[11:6];
			column_q <= s_axis_tdata[13:12];
			root_q <= s_axis_tuser;
			bone_ok_q <= 9'(s_axis_tdata[5:0]) < 9'(MAX_BONES);
			par_ok_q <= 9'(s_axis_tdata[11:6]) < 9'(MAX_BONES);
			for (int r = 0; r < NUM_ROWS; r++) begin
				a_q[r] <= s_axis_tdata[A_OFFSET + WORD_W * r +: WORD_W];
				b_q[r] <= s_axis_tdata[B_OFFSET + WORD_W * r +: WORD_W];
			end
			wa_q <= wa_next;
			wb_q <= ONE_Q15 - wa_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
		end else begin
			state_q <= state_d;
			step_q <= step_d;
		end
	end

	always_comb begin
		state_d = state_q;
		step_d = step_q;
		s_axis_tready = 1'b0;
		load = 1'b0;
		ctrl = '0;
		ctrl.parent = parent_q;
		ctrl.bone = bone_q;
		ctrl.column = column_q;
		ctrl.root = root_q;
		ctrl.par_zero = !par_ok_q;
		ctrl.rd_k = step_q[1:0];
		ctrl.mul_k = 2'(step_q - 3'd1);
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = ST_BLEND;
				end
			end
			ST_BLEND: begin
				ctrl.blend_en = 1'b1;
				state_d = ST_NORM;
			end
			ST_NORM: begin
				ctrl.norm_en = 1'b1;
				ctrl.acc_init = 1'b1;
				step_d = '0;
				state_d = root_q ? ST_FIN : ST_MAC;
			end
			ST_MAC: begin
				ctrl.rd_en = step_q <= 3'd3;
				ctrl.mul_en = step_q >= 3'd1 && step_q <= 3'd4;
				ctrl.acc_en = step_q >= 3'd2;
				step_d = step_q + 3'd1;
				if (step_q == 3'd5) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					load = 1'b1;
					ctrl.wr_en = bone_ok_q;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	for (genvar r = 0; r < NUM_ROWS; r++) begin : g_lane
		spb_lane #(
			.MAX_BONES(MAX_BONES)
		) u_lane (
			.clk(clk),
			.ctrl(ctrl),
			.a_val(a_q[r]),
			.b_val(b_q[r]),
			.wa(wa_q),
			.wb(wb_q),
			.blend_col(blend_col),
			.blended(blend_col[r]),
			.result(results[r])
		);
	end

	spb_merge u_merge (
		.clk(clk),
		.arst_n(arst_n),
		.load(load),
		.bone(bone_q),
		.column(column_q),
		.results(results),
		.free(out_free),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_BLEND)
		else $error("An accepted request did not start the blend.");

	assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.wr_en |-> (bone_ok_q && load))
		else $error("The world store was written without a matching result.");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MAC |-> step_q <= 3'd5)
		else $error("The multiply-accumulate step ran past its last step.");

endmodule

// ===== tb/skeletal_pose_blend_checker.sv =====
// Checker for the skeletal pose blend block: watches the request, result and register
// channels, predicts each world column from its own pose store and compares.
// Depends on spb_pkg for widths, field offsets and register indexes.
`timescale 1ns / 1ps

module skeletal_pose_blend_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	input  logic                           s_axis_tready,
	input  logic [spb_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                           s_axis_tuser,
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	input  logic [spb_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [15:0]                    cfg_data,
	output int                             failures,
	output int                             outstanding
);
	import spb_pkg::*;

	typedef struct packed {
		logic [5:0]                         bone;
		logic [1:0]                         column;
		logic [NUM_ROWS-1:0][WORD_W-1:0]    rows;
	} world_col_t;

	word_t       pose_world [64][4][4];
	logic [15:0] blend_weight = ONE_Q15;
	logic        weight_on_first = 1'b1;
	world_col_t  expected_columns [$];
	world_col_t  want;
	world_col_t  got;
	int          row;

	function automatic word_t clip_word(input logic signed [67:0] v);
		if (v > 68'sd2147483647)
			return 32'sh7FFF_FFFF;
		if (v < -68'sd2147483648)
			return 32'sh8000_0000;
		return v[WORD_W-1:0];
	endfunction

	function automatic world_col_t predict_column(input logic [IN_DATA_W-1:0] req,
			input logic root);
		logic [5:0]         bone;
		logic [5:0]         parent;
		logic [15:0]        w;
		longint             wa;
		longint             wb;
		longint             a;
		longint             b;
		word_t              elem;
		word_t              blended [4];
		logic signed [67:0] sum;
		logic signed [67:0] pe;
		logic signed [67:0] ce;
		world_col_t         res;
		int                 r;
		int                 k;
		bone = req[5:0];
		parent = req[11:6];
		res.bone = bone;
		res.column = req[13:12];
		w = (blend_weight > ONE_Q15) ? ONE_Q15 : blend_weight;
		wa = w;
		if (!weight_on_first)
			wa = 32768 - wa;
		wb = 32768 - wa;
		for (r = 0; r < NUM_ROWS; r++) begin
			elem = req[A_OFFSET + WORD_W * r +: WORD_W];
			a = elem;
			elem = req[B_OFFSET + WORD_W * r +: WORD_W];
			b = elem;
			blended[r] = clip_word((a * wa + b * wb + 64'sd16384) >>> 15);
		end
		for (r = 0; r < NUM_ROWS; r++) begin
			if (root) begin
				res.rows[r] = blended[r];
			end else begin
				sum = '0;
				for (k = 0; k < NUM_ROWS; k++) begin
					pe = pose_world[parent][k][r];
					ce = blended[k];
					sum = sum + pe * ce;
				end
				res.rows[r] = clip_word((sum + 68'sd32768) >>> 16);
			end
		end
		for (r = 0; r < NUM_ROWS; r++)
			pose_world[bone][res.column][r] = res.rows[r];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_weight = ONE_Q15;
			weight_on_first = 1'b1;
			expected_columns.delete();
			outstanding = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.bone = m_axis_tdata[5:0];
				got.column = m_axis_tdata[7:6];
				for (row = 0; row < NUM_ROWS; row++)
					got.rows[row] = m_axis_tdata[8 + WORD_W * row +: WORD_W];
				if (expected_columns.size() == 0) begin
					$error("unexpected world column: bone %0d column %0d", got.bone, got.column);
					failures++;
				end else begin
					want = expected_columns.pop_front();
					if (got.bone !== want.bone) begin
						$error("out_bone expected %0d actual %0d", want.bone, got.bone);
						failures++;
					end
					if (got.column !== want.column) begin
						$error("out_column expected %0d actual %0d", want.column, got.column);
						failures++;
					end
					for (row = 0; row < NUM_ROWS; row++) begin
						if (got.rows[row] !== want.rows[row]) begin
							$error("world_row%0d expected %08h actual %08h", row,
								want.rows[row], got.rows[row]);
							failures++;
						end
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_columns = {expected_columns,
					predict_column(s_axis_tdata, s_axis_tuser)};
			if (cfg_we) begin
				if (cfg_index == REG_BLEND_WEIGHT)
					blend_weight = cfg_data;
				else
					weight_on_first = cfg_data[0];
			end
			outstanding = expected_columns.size();
		end
	end

endmodule

// ===== tb/skeletal_pose_blend_tb.sv =====
// Top of the skeletal pose blend testbench: clock, reset, request and register stimulus,
// random result back-pressure and the final verdict.
// Depends on spb_pkg, skeletal_pose_blend and skeletal_pose_blend_checker.
`timescale 1ns / 1ps

module skeletal_pose_blend_tb;
	import spb_pkg::*;

	typedef logic [NUM_ROWS-1:0][WORD_W-1:0] column_t;

	localparam int STALL_LIMIT = 2000;
	localparam int PHASES = 6;
	localparam int PHASE_REQUESTS = 255;
	localparam logic [31:0] MAX_Q = 32'h7FFF_FFFF;
	localparam logic [31:0] MIN_Q = 32'h8000_0000;
	localparam logic [31:0] ONE_Q = 32'h0001_0000;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_we;
	logic                  cfg_index;
	logic [15:0]           cfg_data;

	logic [3:0] columns_done [64];
	logic       quiet;
	logic       timed_out;
	int         stall_cycles;
	int         requests_sent;
	int         failures;
	int         outstanding;

	skeletal_pose_blend dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	skeletal_pose_blend_checker pose_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.failures      (failures),
		.outstanding   (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		m_axis_tready <= quiet || ($urandom_range(99) >= 30);
	end

	function automatic logic [31:0] rand_word();
		case ($urandom_range(9))
			0: return MAX_Q;
			1: return MIN_Q;
			2, 3: return $urandom();
			default: return $urandom_range(262143) - 32'd131072;
		endcase
	endfunction

	function automatic column_t rand_column();
		column_t c;
		int      r;
		for (r = 0; r < NUM_ROWS; r++)
			c[r] = rand_word();
		return c;
	endfunction

	function automatic column_t unit_column(input int c);
		column_t v;
		v = '0;
		v[c] = ONE_Q;
		return v;
	endfunction

	// Only bones whose four columns are all stored may serve as a parent.
	function automatic int pick_parent();
		int ready [$];
		int i;
		for (i = 0; i < 64; i++) begin
			if (columns_done[i] == 4'hF)
				ready = {ready, i};
		end
		if (ready.size() == 0)
			return -1;
		return ready[$urandom_range(ready.size() - 1)];
	endfunction

	task automatic send_column(input logic [5:0] bone, input logic [5:0] parent,
			input logic root, input logic [1:0] col, input column_t a, input column_t b);
		if (!quiet) begin
			while ($urandom_range(99) < 30) begin
				s_axis_tvalid <= 1'b0;
				@(negedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {2'b00, b, a, col, parent, bone};
		s_axis_tuser <= root;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		columns_done[bone][col] = 1'b1;
		requests_sent++;
		@(negedge clk);
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
	endtask

	task automatic program_blend(input logic [15:0] weight, input logic on_first);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= REG_BLEND_WEIGHT;
		cfg_data <= weight;
		@(negedge clk);
		cfg_index <= REG_WEIGHT_ON_FIRST;
		cfg_data <= {15'd0, on_first};
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// A frame walks bones in parent-before-child order, all four columns of each.
	task automatic send_frame(input int bones);
		int         n;
		int         c;
		int         first_col;
		int         parent;
		logic       root;
		logic [5:0] bone;
		for (n = 0; n < bones; n++) begin
			bone = 6'($urandom_range(63));
			first_col = $urandom_range(3);
			parent = pick_parent();
			root = (n == 0) || (parent < 0) || ($urandom_range(9) == 0);
			if (parent < 0)
				parent = $urandom_range(63);
			for (c = 0; c < 4; c++)
				send_column(bone, parent[5:0], root, 2'(first_col + c), rand_column(),
					rand_column());
		end
	endtask

	initial begin
		int   i;
		int   c;
		int   phase;
		int   target;
		int   parent;
		logic root;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_BLEND_WEIGHT;
		cfg_data = '0;
		quiet = 1'b0;
		timed_out = 1'b0;
		requests_sent = 0;
		stall_cycles = 0;
		for (i = 0; i < 64; i++)
			columns_done[i] = '0;
		fork
			begin
				repeat (10) @(posedge clk);
				@(negedge clk);
				arst_n <= 1'b1;
				@(negedge clk);

				// Reset weights pass the first animation straight through.
				for (c = 0; c < 4; c++)
					send_column(6'd0, 6'd0, 1'b1, 2'(c), unit_column(c), {4{MIN_Q}});
				for (c = 0; c < 4; c++)
					send_column(6'd1, 6'd0, 1'b0, 2'(c), {32'hFFFF_FFFF, 32'd1, MIN_Q, MAX_Q},
						{4{MAX_Q}});
				for (c = 0; c < 4; c++)
					send_column(6'd2, 6'd0, 1'b1, 2'(c), {4{MAX_Q}}, '0);
				send_column(6'd3, 6'd2, 1'b0, 2'd0, {4{MAX_Q}}, '0);
				send_column(6'd3, 6'd2, 1'b0, 2'd1, {4{MIN_Q}}, '0);
				send_column(6'd3, 6'd2, 1'b0, 2'd2, {MIN_Q, MAX_Q, 32'd0, ONE_Q}, '0);
				send_column(6'd2, 6'd2, 1'b0, 2'd3, {4{ONE_Q}}, '0);
				send_column(6'd63, 6'd63, 1'b1, 2'd3, {4{MAX_Q}}, {4{MIN_Q}});

				program_blend(16'd16384, 1'b0);
				send_column(6'd4, 6'd63, 1'b1, 2'd0, {MIN_Q, MAX_Q, 32'hFFFF_FFFF, 32'd1},
					{MAX_Q, MIN_Q, 32'd0, 32'd0});
				send_column(6'd5, 6'd1, 1'b0, 2'd1, {ONE_Q, MIN_Q, MAX_Q, 32'd3},
					{4{32'h0000_8000}});
				program_blend(16'hFFFF, 1'b0);
				send_column(6'd6, 6'd0, 1'b1, 2'd2, {4{MAX_Q}},
					{32'd7, MIN_Q, ONE_Q, 32'hFFFF_0000});
				program_blend(16'd0, 1'b1);
				send_column(6'd6, 6'd0, 1'b1, 2'd3, {4{MAX_Q}},
					{32'd7, MIN_Q, ONE_Q, 32'hFFFF_0000});
				program_blend(16'd32769, 1'b1);
				send_column(6'd7, 6'd1, 1'b0, 2'd0, rand_column(), rand_column());

				for (phase = 0; phase < PHASES; phase++) begin
					case (phase)
						0: program_blend(16'd32768, 1'b0);
						1: program_blend(16'd0, 1'b0);
						2: program_blend(16'hFFFF, 1'b1);
						3: program_blend(16'($urandom_range(32768)), 1'b1);
						4: program_blend(16'($urandom()), 1'($urandom_range(1)));
						default: program_blend(16'($urandom_range(32768)), 1'b0);
					endcase
					quiet <= (phase == 2);
					target = requests_sent + PHASE_REQUESTS;
					while (requests_sent < target) begin
						if ($urandom_range(99) < 80) begin
							send_frame($urandom_range(8, 2));
						end else begin
							parent = pick_parent();
							root = (parent < 0) || ($urandom_range(1) == 1);
							if (parent < 0)
								parent = $urandom_range(63);
							send_column(6'($urandom_range(63)), parent[5:0], root,
								2'($urandom_range(3)), rand_column(), rand_column());
						end
					end
				end

				settle();
				repeat (12) @(negedge clk);
			end
			begin
				while (stall_cycles < STALL_LIMIT) begin
					@(posedge clk);
					if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
							|| cfg_we)
						stall_cycles = 0;
					else
						stall_cycles++;
				end
				timed_out = 1'b1;
			end
		join_any
		if (!timed_out && failures == 0 && outstanding == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/spb_pkg.sv
hdl/spb_lane.sv
hdl/spb_merge.sv
hdl/skeletal_pose_blend.sv
tb/skeletal_pose_blend_checker.sv
tb/skeletal_pose_blend_tb.sv
